// File: design/ncsm_pkg.sv
// ----------------------------------------------------------------------------
// ncsm_pkg
// Shared constants, register codes and pipeline types of the 3x3 color
// similarity mask block.
// ----------------------------------------------------------------------------
package ncsm_pkg;

  // Line geometry
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned AddrW    = $clog2(MaxWidth);

  // Pixel and distance widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ColorW  = ChanW * NumChan;
  localparam int unsigned SqW     = 2 * ChanW;
  localparam int unsigned DistW   = 18;
  localparam int unsigned NumNbr  = 8;

  // Register widths
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 12;
  localparam int unsigned ThrW    = 18;
  localparam int unsigned PendW   = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 18;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThreshold   = 2'd2;

  // Register reset values
  localparam logic [WidthW-1:0]  ResetWidth     = 11'd640;
  localparam logic [HeightW-1:0] ResetHeight    = 12'd480;
  localparam logic [ThrW-1:0]    ResetThreshold = 18'd2500;

  // Effective width limits
  localparam logic [WidthW-1:0] MinWidthEff = 11'd2;
  localparam logic [WidthW-1:0] MaxWidthEff = WidthW'(MaxWidth);

  // Beat modes
  localparam logic ModePixel = 1'b0;
  localparam logic ModeDrain = 1'b1;

  // One slot shifted through the line stores and window
  typedef struct packed {
    logic              emit;
    logic [AddrW-1:0]  addr;
    logic [ColorW-1:0] color;
    logic [NumNbr-1:0] nbr_ok;
    logic              frame_end;
  } ncsm_item_t;

  // Finished mask from the distance stages
  typedef struct packed {
    logic [NumNbr-1:0] mask;
    logic              frame_end;
  } ncsm_res_t;

endpackage

// File: design/ncsm_lstore.sv
// ----------------------------------------------------------------------------
// ncsm_lstore
// Upper and middle line stores in one synchronous memory, one entry per
// column. Read data is registered; a write to the entry being read in the
// same cycle is forwarded.
// ----------------------------------------------------------------------------
module ncsm_lstore (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [ncsm_pkg::AddrW-1:0]    rd_addr_i,
  output logic [2*ncsm_pkg::ColorW-1:0] rd_data_o,
  input  logic                          wr_en_i,
  input  logic [ncsm_pkg::AddrW-1:0]    wr_addr_i,
  input  logic [2*ncsm_pkg::ColorW-1:0] wr_data_i
);
  import ncsm_pkg::*;

  logic [2*ColorW-1:0] mem_q [MaxWidth];
  logic [2*ColorW-1:0] rd_q;
  logic [2*ColorW-1:0] fwd_data_q;
  logic                fwd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Flag a read that collides with the write of the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// File: design/ncsm_seq.sv
// ----------------------------------------------------------------------------
// ncsm_seq
// Arrival and center position counters, owed-mask count and drain state.
// Decides per beat whether it enters the pipeline and whether it emits.
// ----------------------------------------------------------------------------
module ncsm_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        mode_i,
  input  logic [ncsm_pkg::ColorW-1:0] pixel_i,
  input  logic [ncsm_pkg::WidthW-1:0] width_i,
  input  logic [ncsm_pkg::HeightW-1:0] height_i,
  output logic                        take_o,
  output ncsm_pkg::ncsm_item_t        item_o
);
  import ncsm_pkg::*;

  logic [AddrW-1:0]   col_q, col_d, col_e, col_n;
  logic [HeightW-1:0] row_q, row_d, row_e, row_n;
  logic [AddrW-1:0]   cc_q, cc_d, cc_e, cc_n;
  logic [HeightW-1:0] cr_q, cr_d, cr_e, cr_n;
  logic [PendW-1:0]   pend_q, pend_d, pend_e, pend_inc;
  logic               drain_q, drain_d;

  logic               restart;
  logic               emit;
  logic [WidthW-1:0]  col_inc, cc_inc;
  logic [HeightW:0]   row_inc, cr_inc;
  logic               col_last, cc_last, row_last, cr_last;
  logic               up_ok, dn_ok, lf_ok, rt_ok;

  // A pixel after a drain starts a fresh frame
  assign restart = (mode_i == ModePixel) && drain_q;
  assign col_e   = restart ? '0 : col_q;
  assign row_e   = restart ? '0 : row_q;
  assign cc_e    = restart ? '0 : cc_q;
  assign cr_e    = restart ? '0 : cr_q;
  assign pend_e  = restart ? '0 : pend_q;

  // A drain with nothing owed is dropped
  assign take_o = !((mode_i == ModeDrain) && (pend_q == '0));

  // Advance the arrival position
  assign col_inc  = WidthW'(col_e) + WidthW'(1);
  assign col_last = col_inc >= width_i;
  assign row_inc  = (HeightW+1)'(row_e) + (HeightW+1)'(1);
  assign row_last = row_inc >= {1'b0, height_i};
  assign col_n    = col_last ? '0 : col_inc[AddrW-1:0];
  assign row_n    = col_last ? (row_last ? '0 : row_inc[HeightW-1:0]) : row_e;

  // Advance the center position
  assign cc_inc  = WidthW'(cc_e) + WidthW'(1);
  assign cc_last = cc_inc >= width_i;
  assign cr_inc  = (HeightW+1)'(cr_e) + (HeightW+1)'(1);
  assign cr_last = cr_inc >= {1'b0, height_i};
  assign cc_n    = cc_last ? '0 : cc_inc[AddrW-1:0];
  assign cr_n    = cc_last ? (cr_last ? '0 : cr_inc[HeightW-1:0]) : cr_e;

  // Emit on every drain, or once more than a row plus one is owed
  assign pend_inc = pend_e + PendW'(1);
  assign emit     = (mode_i == ModeDrain) || (pend_e > width_i);

  // Frame edge checks around the center
  assign up_ok = cr_e != '0;
  assign dn_ok = !cr_last;
  assign lf_ok = cc_e != '0;
  assign rt_ok = !cc_last;

  always_comb begin
    item_o.emit      = emit;
    item_o.addr      = col_e;
    item_o.color     = (mode_i == ModeDrain) ? '0 : pixel_i;
    // bit order: top-left, top, top-right, left, right, bottom-left, bottom, bottom-right
    item_o.nbr_ok    = {dn_ok & rt_ok, dn_ok, dn_ok & lf_ok, rt_ok, lf_ok,
                        up_ok & rt_ok, up_ok, up_ok & lf_ok};
    item_o.frame_end = (cc_inc == width_i) && (cr_inc == {1'b0, height_i});
  end

  // Next counter state
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    cc_d    = cc_q;
    cr_d    = cr_q;
    pend_d  = pend_q;
    drain_d = drain_q;
    if (accept_i && take_o) begin
      if (mode_i == ModeDrain) begin
        if (pend_q == PendW'(1)) begin
          col_d   = '0;
          row_d   = '0;
          cc_d    = '0;
          cr_d    = '0;
          pend_d  = '0;
          drain_d = 1'b0;
        end else begin
          col_d   = col_n;
          row_d   = row_n;
          cc_d    = cc_n;
          cr_d    = cr_n;
          pend_d  = pend_q - PendW'(1);
          drain_d = 1'b1;
        end
      end else begin
        col_d   = col_n;
        row_d   = row_n;
        cc_d    = emit ? cc_n : cc_e;
        cr_d    = emit ? cr_n : cr_e;
        pend_d  = emit ? pend_e : pend_inc;
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      cc_q    <= '0;
      cr_q    <= '0;
      pend_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      cc_q    <= cc_d;
      cr_q    <= cr_d;
      pend_q  <= pend_d;
      drain_q <= drain_d;
    end
  end

endmodule

// File: design/ncsm_window.sv
// ----------------------------------------------------------------------------
// ncsm_window
// 3x3 pixel window, squared channel differences and the threshold compare
// that forms the neighbor mask.
// ----------------------------------------------------------------------------
module ncsm_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  ncsm_pkg::ncsm_item_t        item_i,
  input  logic [ncsm_pkg::ColorW-1:0] top_i,
  input  logic [ncsm_pkg::ColorW-1:0] mid_i,
  input  logic [ncsm_pkg::ThrW-1:0]   thr_i,
  output logic                        res_valid_o,
  output ncsm_pkg::ncsm_res_t         res_o
);
  import ncsm_pkg::*;

  logic [ColorW-1:0] win_q [3][3];
  logic [ColorW-1:0] nbr [NumNbr];
  logic [SqW-1:0]    sq_d [NumNbr][NumChan];
  logic [SqW-1:0]    sq_q [NumNbr][NumChan];
  logic [ChanW-1:0]  ca, cb, diff;
  logic [DistW-1:0]  dist_sum [NumNbr];

  logic              s3_valid_q, s4_valid_q;
  logic [NumNbr-1:0] s3_inside_q, s4_inside_q;
  logic              s3_fe_q, s4_fe_q;

  // Shift the window one column left and load the new right column
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top_i;
      win_q[1][2] <= mid_i;
      win_q[2][2] <= item_i.color;
    end
  end

  // Neighbors in mask bit order
  always_comb begin
    nbr[0] = win_q[0][0];
    nbr[1] = win_q[0][1];
    nbr[2] = win_q[0][2];
    nbr[3] = win_q[1][0];
    nbr[4] = win_q[1][2];
    nbr[5] = win_q[2][0];
    nbr[6] = win_q[2][1];
    nbr[7] = win_q[2][2];
  end

  // Square the per-channel differences to the center
  always_comb begin
    ca   = '0;
    cb   = '0;
    diff = '0;
    for (int n = 0; n < NumNbr; n++) begin
      for (int c = 0; c < NumChan; c++) begin
        ca   = win_q[1][1][c*ChanW +: ChanW];
        cb   = nbr[n][c*ChanW +: ChanW];
        diff = (ca > cb) ? (ca - cb) : (cb - ca);
        sq_d[n][c] = SqW'(diff) * SqW'(diff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv_i) begin
      s3_valid_q <= valid_i && item_i.emit;
      s4_valid_q <= s3_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_inside_q <= item_i.nbr_ok;
      s3_fe_q     <= item_i.frame_end;
      s4_inside_q <= s3_inside_q;
      s4_fe_q     <= s3_fe_q;
      sq_q        <= sq_d;
    end
  end

  // Sum the channels and compare against the threshold
  always_comb begin
    for (int n = 0; n < NumNbr; n++) begin
      dist_sum[n] = DistW'(sq_q[n][0]) + DistW'(sq_q[n][1]) + DistW'(sq_q[n][2]);
      res_o.mask[n] = s4_inside_q[n] && (dist_sum[n] < thr_i);
    end
    res_o.frame_end = s4_fe_q;
  end

  assign res_valid_o = s4_valid_q;

endmodule

// File: design/neighbor_color_similarity_mask_top.sv
// ----------------------------------------------------------------------------
// neighbor_color_similarity_mask_top
// 3x3 color similarity mask over a raster pixel stream, with two line stores
// held in one synchronous memory and a configuration write port.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle, set by the single read-modify-write of the
//   line-store memory per beat; stalls only when a mask meets a full output.
// Pipeline: the beat that completes a mask (the beat frame_width+1 positions
//   after its pixel) passes the memory read, window and squares registers, a
//   combinational sum and compare, then the output register.
// Reset: counters, drain state and pipeline valids clear; registers load 640,
//   480 and 2500; line stores and window are not cleared.
module neighbor_color_similarity_mask_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [ncsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ncsm_pkg::CfgDataW-1:0] cfg_wr_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [ncsm_pkg::ColorW-1:0]   pixel_color_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ncsm_pkg::NumNbr-1:0]   similarity_mask_o,
  output logic                          frame_end_o
);
  import ncsm_pkg::*;

  logic [WidthW-1:0]   width_q, width_eff;
  logic [HeightW-1:0]  height_q, height_eff;
  logic [ThrW-1:0]     thr_q;

  logic                adv;
  logic                accept;
  logic                take;
  ncsm_item_t          item;
  logic                s2_valid_q;
  ncsm_item_t          s2_q;
  logic [2*ColorW-1:0] rd_data;
  logic                res_valid;
  ncsm_res_t           res;
  logic                out_valid_q;
  ncsm_res_t           out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      thr_q    <= ResetThreshold;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  width_q  <= cfg_wr_data_i[WidthW-1:0];
        CfgFrameHeight: height_q <= cfg_wr_data_i[HeightW-1:0];
        CfgThreshold:   thr_q    <= cfg_wr_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame width to what the line stores hold; a zero height counts as one
  always_comb begin
    priority if (width_q < MinWidthEff) begin
      width_eff = MinWidthEff;
    end else if (width_q > MaxWidthEff) begin
      width_eff = MaxWidthEff;
    end else begin
      width_eff = width_q;
    end
    height_eff = (height_q == '0) ? HeightW'(1) : height_q;
  end

  // Stall only when a finished mask meets a full, unread output register
  assign adv        = !(res_valid && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;
  assign accept     = in_valid_i && in_ready_o;

  ncsm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (mode_i),
    .pixel_i  (pixel_color_i),
    .width_i  (width_eff),
    .height_i (height_eff),
    .take_o   (take),
    .item_o   (item)
  );

  // Hold the slot while its line-store read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= accept && take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && take) begin
      s2_q <= item;
    end
  end

  // Read the column, then write back middle-to-upper and the new pixel
  ncsm_lstore u_lstore (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && take),
    .rd_addr_i (item.addr),
    .rd_data_o (rd_data),
    .wr_en_i   (adv && s2_valid_q),
    .wr_addr_i (s2_q.addr),
    .wr_data_i ({rd_data[ColorW-1:0], s2_q.color})
  );

  ncsm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (s2_valid_q),
    .item_i      (s2_q),
    .top_i       (rd_data[2*ColorW-1:ColorW]),
    .mid_i       (rd_data[ColorW-1:0]),
    .thr_i       (thr_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign similarity_mask_o = out_q.mask;
  assign frame_end_o       = out_q.frame_end;

endmodule

// File: design/ncsm_checker.sv
// ----------------------------------------------------------------------------
// ncsm_checker
// Port-level checks of the similarity mask block, bound to its top level.
// ----------------------------------------------------------------------------
module ncsm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ncsm_pkg::NumNbr-1:0] similarity_mask_o,
  input logic                        frame_end_o
);
  import ncsm_pkg::*;

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(similarity_mask_o) && $stable(frame_end_o))
    else $error("output beat changed while stalled");

  // Drop the output beat only when taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output beat dropped without being taken");

  // Stall the input only behind a blocked output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A new mask on a free-running pipe comes from a beat taken earlier, through the pipeline registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && $past(in_ready_o, 1) && $past(in_ready_o, 2) &&
      $past(in_ready_o, 3) && $past(in_ready_o, 4) |-> $past(in_valid_i, 4))
    else $error("mask appeared without a matching input beat");

endmodule

bind neighbor_color_similarity_mask_top ncsm_checker u_ncsm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .similarity_mask_o (similarity_mask_o),
  .frame_end_o       (frame_end_o)
);

// File: tb/sv/ncsm_mask_checker.sv
// ----------------------------------------------------------------------------
// ncsm_mask_checker
// Watches the configuration port and both streams of the 3x3 color similarity
// mask block, predicts every mask from the accepted pixel and drain beats, and
// compares each output beat against the oldest predicted mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncsm_mask_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [ncsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ncsm_pkg::CfgDataW-1:0] cfg_wr_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          mode_i,
  input  logic [ncsm_pkg::ColorW-1:0]   pixel_color_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [ncsm_pkg::NumNbr-1:0]   similarity_mask_i,
  input  logic                          frame_end_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   masks_due_o,
  output int unsigned                   masks_checked_o,
  output int unsigned                   frame_ends_o
);
  import ncsm_pkg::*;

  // Shadow registers
  logic [WidthW-1:0]  width_reg;
  logic [HeightW-1:0] height_reg;
  logic [ThrW-1:0]    thr_reg;

  // Line stores, window and stream positions
  logic [ColorW-1:0] upper_row_q  [MaxWidth];
  logic [ColorW-1:0] middle_row_q [MaxWidth];
  logic [ColorW-1:0] win_q [3][3];
  int unsigned       in_col, in_row;
  int unsigned       ctr_col, ctr_row;
  int unsigned       owed_cnt;
  bit                in_drain;

  // Masks predicted but not yet seen on the output
  ncsm_res_t mask_due_q[$];
  ncsm_res_t want_r;

  function automatic int unsigned live_width();
    int unsigned w;
    w = width_reg;
    if (w < MinWidthEff) w = MinWidthEff;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int unsigned live_height();
    return (height_reg == '0) ? 1 : height_reg;
  endfunction

  // Squared RGB distance between two packed pixels
  function automatic int unsigned color_gap(input logic [ColorW-1:0] a,
                                            input logic [ColorW-1:0] b);
    int unsigned sum;
    int unsigned x, y, d;
    sum = 0;
    for (int s = 0; s < NumChan; s++) begin
      x = a[s*ChanW +: ChanW];
      y = b[s*ChanW +: ChanW];
      d = (x > y) ? x - y : y - x;
      sum += d * d;
    end
    return sum;
  endfunction

  // Advance a raster position, wrapping at row and frame end
  function automatic void step_pos(inout int unsigned col, inout int unsigned row,
                                   input int unsigned w, input int unsigned h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col++;
    end
  endfunction

  task automatic restart_frame();
    in_col   = 0;
    in_row   = 0;
    ctr_col  = 0;
    ctr_row  = 0;
    owed_cnt = 0;
    in_drain = 0;
  endtask

  // Push one slot through the line stores and the window
  task automatic shift_slot(input logic [ColorW-1:0] color, input int unsigned w,
                            input int unsigned h);
    logic [ColorW-1:0] top_px, mid_px;
    top_px = upper_row_q[in_col];
    mid_px = middle_row_q[in_col];
    upper_row_q[in_col]  = mid_px;
    middle_row_q[in_col] = color;
    for (int r = 0; r < 3; r++) begin
      win_q[r][0] = win_q[r][1];
      win_q[r][1] = win_q[r][2];
    end
    win_q[0][2] = top_px;
    win_q[1][2] = mid_px;
    win_q[2][2] = color;
    step_pos(in_col, in_row, w, h);
  endtask

  // Compare the window center with its eight neighbors, edges cleared
  task automatic build_mask(input int unsigned w, input int unsigned h,
                            output ncsm_res_t res);
    logic [ColorW-1:0] ctr_px;
    int unsigned       k;
    bit                hit;
    ctr_px = win_q[1][1];
    res    = '0;
    k      = 0;
    for (int dy = 0; dy < 3; dy++)
      for (int dx = 0; dx < 3; dx++) begin
        if (dy == 1 && dx == 1) continue;
        hit = 1;
        if (dx == 0 && ctr_col == 0) hit = 0;
        if (dx == 2 && ctr_col + 1 >= w) hit = 0;
        if (dy == 0 && ctr_row == 0) hit = 0;
        if (dy == 2 && ctr_row + 1 >= h) hit = 0;
        if (hit && color_gap(ctr_px, win_q[dy][dx]) < thr_reg) res.mask[k] = 1'b1;
        k++;
      end
    res.frame_end = (ctr_col + 1 == w && ctr_row + 1 == h);
    step_pos(ctr_col, ctr_row, w, h);
  endtask

  // Work out the mask, if any, that one accepted beat releases
  task automatic predict_beat(input logic mode, input logic [ColorW-1:0] color);
    int unsigned w, h;
    ncsm_res_t   res;
    w = live_width();
    h = live_height();
    if (mode == ModeDrain) begin
      if (owed_cnt != 0) begin
        in_drain = 1;
        shift_slot('0, w, h);
        build_mask(w, h, res);
        mask_due_q.push_back(res);
        owed_cnt--;
        if (owed_cnt == 0) restart_frame();
      end
    end else begin
      if (in_drain) restart_frame();
      shift_slot(color, w, h);
      owed_cnt++;
      if (owed_cnt > w + 1) begin
        build_mask(w, h, res);
        mask_due_q.push_back(res);
        owed_cnt--;
      end
    end
  endtask

  // Track registers, predict on input beats, check output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = ResetWidth;
      height_reg = ResetHeight;
      thr_reg    = ResetThreshold;
      for (int i = 0; i < MaxWidth; i++) begin
        upper_row_q[i]  = '0;
        middle_row_q[i] = '0;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win_q[r][c] = '0;
      restart_frame();
      mask_due_q.delete();
      fail_cnt_o      = 0;
      masks_due_o     = 0;
      masks_checked_o = 0;
      frame_ends_o    = 0;
    end else begin
      if (cfg_wr_en_i) begin
        case (cfg_index_i)
          CfgFrameWidth:  width_reg  = cfg_wr_data_i[WidthW-1:0];
          CfgFrameHeight: height_reg = cfg_wr_data_i[HeightW-1:0];
          CfgThreshold:   thr_reg    = cfg_wr_data_i[ThrW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_beat(mode_i, pixel_color_i);
      if (out_valid_i && out_ready_i) begin
        if (mask_due_q.size() == 0) begin
          $error("similarity_mask: no mask expected, got %02h (frame_end %0b)",
                 similarity_mask_i, frame_end_i);
          fail_cnt_o++;
        end else begin
          want_r = mask_due_q.pop_front();
          masks_checked_o++;
          if (frame_end_i === 1'b1) frame_ends_o++;
          if (similarity_mask_i !== want_r.mask) begin
            $error("similarity_mask: expected %02h, got %02h", want_r.mask,
                   similarity_mask_i);
            fail_cnt_o++;
          end
          if (frame_end_i !== want_r.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want_r.frame_end, frame_end_i);
            fail_cnt_o++;
          end
        end
      end
      masks_due_o = mask_due_q.size();
    end
  end

endmodule

// File: tb/sv/neighbor_color_similarity_mask_top_tb.sv
// ----------------------------------------------------------------------------
// neighbor_color_similarity_mask_top_tb
// Drives pixel and drain beats through the 3x3 color similarity mask block
// under several frame sizes and thresholds, with random gaps and output
// stalls; the mask checker predicts and compares every output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module neighbor_color_similarity_mask_top_tb;
  import ncsm_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ThrMax       = 195076;
  localparam int unsigned NoPause      = 32'hFFFF_FFFF;

  // Colors at the corners and edges of the channel ranges
  localparam logic [ColorW-1:0] ProbePx [12] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hAAAAAA,
    24'h555555, 24'h000001, 24'hFFFFFE, 24'h7F7F7F, 24'h808080, 24'h010101
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_wr_en_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wr_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                mode_i;
  logic [ColorW-1:0]   pixel_color_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [NumNbr-1:0]   similarity_mask_o;
  logic                frame_end_o;

  int unsigned fail_cnt, masks_due, masks_checked, frame_ends;
  int unsigned beats_sent, settings_used, cycle_cnt;
  bit          idle_on;
  logic [ColorW-1:0] paint;

  neighbor_color_similarity_mask_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .pixel_color_i     (pixel_color_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .similarity_mask_o (similarity_mask_o),
    .frame_end_o       (frame_end_o)
  );

  ncsm_mask_checker mask_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .mode_i            (mode_i),
    .pixel_color_i     (pixel_color_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .similarity_mask_i (similarity_mask_o),
    .frame_end_i       (frame_end_o),
    .fail_cnt_o        (fail_cnt),
    .masks_due_o       (masks_due),
    .masks_checked_o   (masks_checked),
    .frame_ends_o      (frame_ends)
  );

  // 100 MHz clock
  always #5 clk_i = ~clk_i;

  // Stall the output now and then
  always @(negedge clk_i) begin
    out_ready_i <= !(idle_on && $urandom_range(0, 99) < 15);
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one beat, with an optional random gap first, and hold it until taken
  task automatic send_beat(input logic mode, input logic [ColorW-1:0] color);
    @(negedge clk_i);
    while (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    pixel_color_i <= color;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // Wait until every predicted mask is out and the pipeline is empty
  task automatic drain_out();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (masks_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Load frame size and threshold while the block is idle
  task automatic set_frame(input int unsigned w, input int unsigned h,
                           input int unsigned thr);
    drain_out();
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_index_i   <= CfgFrameWidth;
    cfg_wr_data_i <= CfgDataW'(w);
    @(negedge clk_i);
    cfg_index_i   <= CfgFrameHeight;
    cfg_wr_data_i <= CfgDataW'(h);
    @(negedge clk_i);
    cfg_index_i   <= CfgThreshold;
    cfg_wr_data_i <= CfgDataW'(thr);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    settings_used++;
  endtask

  // Drain enough steps to release every mask still owed
  task automatic flush_frame(input int unsigned n_steps);
    repeat (n_steps) send_beat(ModeDrain, ColorW'($urandom()));
  endtask

  // Random frames: mostly pixels of nearby colors, with short and full drains
  task automatic run_phase(input int unsigned w, input int unsigned h,
                           input int unsigned thr, input int unsigned n_beats,
                           input bit calm, input int unsigned pause_at);
    int unsigned done, pick, burst, full;
    bit          paused;
    logic [ColorW-1:0] px;
    set_frame(w, h, thr);
    idle_on = !calm;
    done    = 0;
    paused  = 0;
    // owed masks never exceed a row plus one, nor the pixels sent in the phase
    full    = (w + 1 < n_beats) ? w + 1 : n_beats;
    while (done < n_beats) begin
      if (!paused && done >= pause_at) begin
        // hold off until the block has caught up
        drain_out();
        paused = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        if ($urandom_range(0, 9) == 0) paint = ColorW'($urandom());
        case ($urandom_range(0, 3))
          0: px = ColorW'($urandom());
          1: px = paint ^ (ColorW'($urandom()) & 24'h010101);
          2: px = paint ^ (ColorW'($urandom()) & 24'h070707);
          default: px = paint ^ (ColorW'($urandom()) & 24'h1F1F1F);
        endcase
        send_beat(ModePixel, px);
        done++;
      end else begin
        burst = (pick < 96) ? $urandom_range(1, 3) : full;
        repeat (burst) send_beat(ModeDrain, ColorW'($urandom()));
        done += burst;
      end
    end
    flush_frame(full);
    idle_on = 1;
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_index_i   = CfgFrameWidth;
    cfg_wr_data_i = '0;
    in_valid_i    = 1'b0;
    mode_i        = ModePixel;
    pixel_color_i = '0;
    out_ready_i   = 1'b0;
    cycle_cnt     = 0;
    beats_sent    = 0;
    settings_used = 0;
    idle_on       = 1;
    paint         = ColorW'($urandom());
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: small frame, every neighbor passes the widest threshold
    set_frame(4, 3, ThrMax);
    send_beat(ModeDrain, 24'hFFFFFF);           // nothing owed yet
    foreach (ProbePx[k]) send_beat(ModePixel, ProbePx[k]);
    for (int k = 0; k < 3; k++) send_beat(ModePixel, ProbePx[11-k]);  // next frame
    repeat (2) send_beat(ModeDrain, '0);        // cut the frame short
    send_beat(ModePixel, 24'h123456);           // drop what the drain still owes
    flush_frame(5);

    // Random phases across sizes and thresholds
    run_phase(2, 1, 0, 60, 0, NoPause);
    run_phase(5, 4, $urandom_range(200, 3000), 200, 1, NoPause);
    run_phase(3, 4095, ThrMax, 100, 0, NoPause);
    run_phase(8, 6, $urandom_range(0, 1500), 250, 0, 120);
    run_phase(MaxWidth, 1, $urandom_range(0, ThrMax), 40, 0, NoPause);
    run_phase(16, 3, $urandom_range(0, 4000), 150, 0, NoPause);

    drain_out();
    $display("Sent %0d beats over %0d register settings; checked %0d masks, %0d at frame end.",
             beats_sent, settings_used, masks_checked, frame_ends);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ncsm_pkg.sv
design/ncsm_lstore.sv
design/ncsm_seq.sv
design/ncsm_window.sv
design/neighbor_color_similarity_mask_top.sv
design/ncsm_checker.sv
tb/sv/ncsm_mask_checker.sv
tb/sv/neighbor_color_similarity_mask_top_tb.sv
